// ===== rtl/core/iobom_pkg.sv =====
package iobom_pkg;

   // Sizes of the device table and of the event fields.
   localparam int DEVICES     = 8;
   localparam int DEV_BITS    = 3;
   localparam int TYPE_BITS   = 3;
   localparam int TICK_BITS   = 48;
   localparam int BYTE_BITS   = 32;
   localparam int COUNT_BITS  = 32;
   localparam int SUM_BITS    = 64;
   localparam int MAX_PENDING = 255;
   localparam int PEND_BITS   = 8;
   localparam int GPEND_BITS  = 11;
   localparam int PROD_BITS   = PEND_BITS + TICK_BITS;

   // Event codes carried on the request type field.
   typedef enum logic [TYPE_BITS-1:0] {
      EV_READ_START   = 3'd0,
      EV_READ_FINISH  = 3'd1,
      EV_READ_CANCEL  = 3'd2,
      EV_WRITE_START  = 3'd3,
      EV_WRITE_FINISH = 3'd4,
      EV_WRITE_CANCEL = 3'd5,
      EV_QUERY        = 3'd6
   } event_type;

   // What one event does to its direction.
   typedef enum logic [1:0] {
      KIND_START  = 2'd0,
      KIND_FINISH = 2'd1,
      KIND_CANCEL = 2'd2
   } kind_type;

   // Command from the sequencer to the direction update unit.
   typedef struct packed {
      logic     step;
      kind_type kind;
   } dir_cmd_type;

   // Counters of one direction on one device.
   typedef struct packed {
      logic [COUNT_BITS-1:0] count;
      logic [SUM_BITS-1:0]   bytes;
      logic [SUM_BITS-1:0]   occ;
      logic [TICK_BITS-1:0]  last;
      logic [PEND_BITS-1:0]  pend;
   } dir_rec_type;

   // One entry of the device table.
   typedef struct packed {
      dir_rec_type rd;
      dir_rec_type wr;
   } dev_rec_type;

   // Adds two sums and sticks at the top of the range.
   function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] a,
                                                  input logic [SUM_BITS-1:0] b);
      logic [SUM_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
   endfunction

   // Ticks from last to now, zero when time runs backward.
   function automatic logic [TICK_BITS-1:0] elapsed(input logic [TICK_BITS-1:0] now,
                                                   input logic [TICK_BITS-1:0] last);
      return (now >= last) ? now - last : '0;
   endfunction

endpackage

// ===== rtl/core/iobom_dev_mem.sv =====
module iobom_dev_mem (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rd_en,
   input  logic [iobom_pkg::DEV_BITS-1:0]  rd_addr,
   output iobom_pkg::dev_rec_type          rd_data,
   input  logic                            wr_en,
   input  logic [iobom_pkg::DEV_BITS-1:0]  wr_addr,
   input  iobom_pkg::dev_rec_type          wr_data
);
   import iobom_pkg::*;

   dev_rec_type               mem [DEVICES];
   logic [DEVICES-1:0]        valid_ff;
   logic [DEVICES-1:0]        valid_in;
   dev_rec_type               rd_data_ff;
   logic                      rd_valid_ff;

   // Entry valid bits; an entry never written reads as zero.
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // Table storage with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== rtl/core/iobom_dir_unit.sv =====
module iobom_dir_unit (
   input  logic                             clock,
   input  iobom_pkg::dir_cmd_type           cmd,
   input  logic [iobom_pkg::BYTE_BITS-1:0]  bytes,
   input  logic [iobom_pkg::TICK_BITS-1:0]  now,
   input  iobom_pkg::dir_rec_type           rec_in,
   output iobom_pkg::dir_rec_type           rec_out,
   output logic                             pend_up,
   output logic                             pend_down,
   output logic                             err
);
   import iobom_pkg::*;

   logic [COUNT_BITS-1:0] count_in, count_ff;
   logic [SUM_BITS-1:0]   bytes_in, bytes_ff;
   logic [SUM_BITS-1:0]   occ_ff;
   logic [PROD_BITS-1:0]  prod_in, prod_ff;
   logic [TICK_BITS-1:0]  last_ff;
   logic [PEND_BITS-1:0]  pend_in, pend_ff;
   logic                  up_in, up_ff;
   logic                  down_in, down_ff;
   logic                  err_in, err_ff;
   logic [SUM_BITS-1:0]   wide_bytes;

   assign wide_bytes = {{(SUM_BITS-BYTE_BITS){1'b0}}, bytes};

   // First step: counts, bytes, outstanding count and the occupancy product.
   always_comb begin
      count_in = rec_in.count;
      bytes_in = rec_in.bytes;
      pend_in  = rec_in.pend;
      up_in    = 1'b0;
      down_in  = 1'b0;
      err_in   = 1'b0;
      prod_in  = PROD_BITS'(rec_in.pend) * PROD_BITS'(elapsed(now, rec_in.last));
      case (cmd.kind)
         KIND_START: begin
            if (rec_in.count != {COUNT_BITS{1'b1}}) begin
               count_in = rec_in.count + 1'b1;
            end
            bytes_in = sat_add(rec_in.bytes, wide_bytes);
            if (rec_in.pend < PEND_BITS'(MAX_PENDING)) begin
               pend_in = rec_in.pend + 1'b1;
               up_in   = 1'b1;
            end
         end
         default: begin
            if (cmd.kind == KIND_CANCEL) begin
               if (rec_in.count != '0) begin
                  count_in = rec_in.count - 1'b1;
               end
               bytes_in = (rec_in.bytes >= wide_bytes) ? rec_in.bytes - wide_bytes : '0;
            end
            if (rec_in.pend != '0) begin
               pend_in = rec_in.pend - 1'b1;
               down_in = 1'b1;
            end else begin
               err_in = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         count_ff <= count_in;
         bytes_ff <= bytes_in;
         occ_ff   <= rec_in.occ;
         prod_ff  <= prod_in;
         last_ff  <= now;
         pend_ff  <= pend_in;
         up_ff    <= up_in;
         down_ff  <= down_in;
         err_ff   <= err_in;
      end
   end

   // Second step: fold the product into the occupancy integral.
   always_comb begin
      rec_out.count = count_ff;
      rec_out.bytes = bytes_ff;
      rec_out.occ   = sat_add(occ_ff, SUM_BITS'(prod_ff));
      rec_out.last  = last_ff;
      rec_out.pend  = pend_ff;
   end

   assign pend_up   = up_ff;
   assign pend_down = down_ff;
   assign err       = err_ff;

endmodule

// ===== rtl/core/io_busy_occupancy_monitor_unit.sv =====
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  type, device, bytes, tick
// rsp_      out        rsp_valid/rsp_stall  device counters, busy sums, error
//
// An event passes through the table read, the update step with the occupancy
// multiply, and the write-back step; a new event is taken only after write-back.
// The per-device table is one synchronous memory, read once per event and written once per event except a query.
// Reset clears the sequencer, the result valid flag, the global sums, counts and last ticks and the table valid bits.
// A stalled result holds in the output register while the next event is taken;
// write-back waits only when that register is still full.
module io_busy_occupancy_monitor_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [iobom_pkg::TYPE_BITS-1:0]  req_type,
   input  logic [iobom_pkg::DEV_BITS-1:0]   req_device_index,
   input  logic [iobom_pkg::BYTE_BITS-1:0]  req_transfer_bytes,
   input  logic [iobom_pkg::TICK_BITS-1:0]  req_event_tick,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [iobom_pkg::COUNT_BITS-1:0] rsp_dev_read_count,
   output logic [iobom_pkg::COUNT_BITS-1:0] rsp_dev_write_count,
   output logic [iobom_pkg::SUM_BITS-1:0]   rsp_dev_read_bytes,
   output logic [iobom_pkg::SUM_BITS-1:0]   rsp_dev_write_bytes,
   output logic [iobom_pkg::SUM_BITS-1:0]   rsp_dev_read_occupancy,
   output logic [iobom_pkg::SUM_BITS-1:0]   rsp_dev_write_occupancy,
   output logic [iobom_pkg::SUM_BITS-1:0]   rsp_busy_read_ticks,
   output logic [iobom_pkg::SUM_BITS-1:0]   rsp_busy_write_ticks,
   output logic [iobom_pkg::SUM_BITS-1:0]   rsp_busy_io_ticks,
   output logic [iobom_pkg::PEND_BITS-1:0]  rsp_dev_reads_pending,
   output logic [iobom_pkg::PEND_BITS-1:0]  rsp_dev_writes_pending,
   output logic                             rsp_event_error
);
   import iobom_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CALC = 3'b010,
      ST_WB   = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic                   accept;
   logic                   advance;

   logic [TYPE_BITS-1:0]   type_ff;
   logic [DEV_BITS-1:0]    dev_ff;
   logic [BYTE_BITS-1:0]   bytes_ff;
   logic [TICK_BITS-1:0]   tick_ff;

   logic                   is_read;
   logic                   is_write;
   logic                   is_query;
   kind_type               kind;

   dev_rec_type            mem_rd;
   dev_rec_type            new_rec;
   dir_rec_type            dir_in;
   dir_rec_type            dir_out;
   dir_cmd_type            dir_cmd;
   logic                   pend_up;
   logic                   pend_down;
   logic                   dir_err;

   logic [SUM_BITS-1:0]    busy_rd_ff, busy_rd_in;
   logic [SUM_BITS-1:0]    busy_wr_ff, busy_wr_in;
   logic [SUM_BITS-1:0]    busy_io_ff, busy_io_in;
   logic [TICK_BITS-1:0]   glast_rd_ff, glast_rd_in;
   logic [TICK_BITS-1:0]   glast_wr_ff, glast_wr_in;
   logic [TICK_BITS-1:0]   glast_io_ff, glast_io_in;
   logic [GPEND_BITS-1:0]  gpend_rd_ff, gpend_rd_in;
   logic [GPEND_BITS-1:0]  gpend_wr_ff, gpend_wr_in;
   logic [TICK_BITS-1:0]   gdir_el_ff;
   logic [TICK_BITS-1:0]   io_el_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   dev_rec_type            rsp_rec_ff;
   logic [SUM_BITS-1:0]    rsp_busy_rd_ff;
   logic [SUM_BITS-1:0]    rsp_busy_wr_ff;
   logic [SUM_BITS-1:0]    rsp_busy_io_ff;
   logic                   rsp_err_ff;
   logic                   rsp_err_in;

   // Handshakes. Write-back waits while an older result is still stalled.
   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign advance   = (state_ff == ST_WB) && !(rsp_valid_ff && rsp_stall);

   // Event sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            state_in = ST_WB;
         end
         ST_WB: begin
            if (advance) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Transaction capture.
   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff  <= req_type;
         dev_ff   <= req_device_index;
         bytes_ff <= req_transfer_bytes;
         tick_ff  <= req_event_tick;
      end
   end

   // Event decode; the unused code reads as a query.
   always_comb begin
      is_read  = 1'b0;
      is_write = 1'b0;
      kind     = KIND_START;
      unique case (type_ff)
         EV_READ_START: begin
            is_read = 1'b1;
         end
         EV_READ_FINISH: begin
            is_read = 1'b1;
            kind    = KIND_FINISH;
         end
         EV_READ_CANCEL: begin
            is_read = 1'b1;
            kind    = KIND_CANCEL;
         end
         EV_WRITE_START: begin
            is_write = 1'b1;
         end
         EV_WRITE_FINISH: begin
            is_write = 1'b1;
            kind     = KIND_FINISH;
         end
         EV_WRITE_CANCEL: begin
            is_write = 1'b1;
            kind     = KIND_CANCEL;
         end
         default: begin
            kind = KIND_START;
         end
      endcase
      is_query = !is_read && !is_write;
   end

   // Device table; the next read is issued only after the write-back.
   iobom_dev_mem u_dev_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (req_device_index),
      .rd_data (mem_rd),
      .wr_en   (advance && !is_query),
      .wr_addr (dev_ff),
      .wr_data (new_rec)
   );

   // Direction update on the selected half of the entry.
   assign dir_in       = is_write ? mem_rd.wr : mem_rd.rd;
   assign dir_cmd.step = (state_ff == ST_CALC);
   assign dir_cmd.kind = kind;

   iobom_dir_unit u_dir_unit (
      .clock     (clock),
      .cmd       (dir_cmd),
      .bytes     (bytes_ff),
      .now       (tick_ff),
      .rec_in    (dir_in),
      .rec_out   (dir_out),
      .pend_up   (pend_up),
      .pend_down (pend_down),
      .err       (dir_err)
   );

   always_comb begin
      new_rec = mem_rd;
      if (is_read) begin
         new_rec.rd = dir_out;
      end
      if (is_write) begin
         new_rec.wr = dir_out;
      end
   end

   // Elapsed ticks for the global sums, taken in the update step.
   always_ff @(posedge clock) begin
      if (state_ff == ST_CALC) begin
         gdir_el_ff <= elapsed(tick_ff, is_write ? glast_wr_ff : glast_rd_ff);
         io_el_ff   <= elapsed(tick_ff, glast_io_ff);
      end
   end

   // Global busy sums and outstanding counts, using values before the change.
   always_comb begin
      busy_rd_in  = busy_rd_ff;
      busy_wr_in  = busy_wr_ff;
      busy_io_in  = busy_io_ff;
      glast_rd_in = glast_rd_ff;
      glast_wr_in = glast_wr_ff;
      glast_io_in = glast_io_ff;
      gpend_rd_in = gpend_rd_ff;
      gpend_wr_in = gpend_wr_ff;
      if (!is_query) begin
         if ((gpend_rd_ff != '0) || (gpend_wr_ff != '0)) begin
            busy_io_in = sat_add(busy_io_ff, SUM_BITS'(io_el_ff));
         end
         glast_io_in = tick_ff;
      end
      if (is_read) begin
         if (gpend_rd_ff != '0) begin
            busy_rd_in = sat_add(busy_rd_ff, SUM_BITS'(gdir_el_ff));
         end
         glast_rd_in = tick_ff;
         if (pend_up) begin
            gpend_rd_in = gpend_rd_ff + 1'b1;
         end else if (pend_down && (gpend_rd_ff != '0)) begin
            gpend_rd_in = gpend_rd_ff - 1'b1;
         end
      end
      if (is_write) begin
         if (gpend_wr_ff != '0) begin
            busy_wr_in = sat_add(busy_wr_ff, SUM_BITS'(gdir_el_ff));
         end
         glast_wr_in = tick_ff;
         if (pend_up) begin
            gpend_wr_in = gpend_wr_ff + 1'b1;
         end else if (pend_down && (gpend_wr_ff != '0)) begin
            gpend_wr_in = gpend_wr_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_rd_ff  <= '0;
         busy_wr_ff  <= '0;
         busy_io_ff  <= '0;
         glast_rd_ff <= '0;
         glast_wr_ff <= '0;
         glast_io_ff <= '0;
         gpend_rd_ff <= '0;
         gpend_wr_ff <= '0;
      end else if (advance) begin
         busy_rd_ff  <= busy_rd_in;
         busy_wr_ff  <= busy_wr_in;
         busy_io_ff  <= busy_io_in;
         glast_rd_ff <= glast_rd_in;
         glast_wr_ff <= glast_wr_in;
         glast_io_ff <= glast_io_in;
         gpend_rd_ff <= gpend_rd_in;
         gpend_wr_ff <= gpend_wr_in;
      end
   end

   // Output register.
   assign rsp_err_in = !is_query && dir_err;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_rec_ff     <= new_rec;
         rsp_busy_rd_ff <= busy_rd_in;
         rsp_busy_wr_ff <= busy_wr_in;
         rsp_busy_io_ff <= busy_io_in;
         rsp_err_ff     <= rsp_err_in;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_dev_read_count      = rsp_rec_ff.rd.count;
   assign rsp_dev_write_count     = rsp_rec_ff.wr.count;
   assign rsp_dev_read_bytes      = rsp_rec_ff.rd.bytes;
   assign rsp_dev_write_bytes     = rsp_rec_ff.wr.bytes;
   assign rsp_dev_read_occupancy  = rsp_rec_ff.rd.occ;
   assign rsp_dev_write_occupancy = rsp_rec_ff.wr.occ;
   assign rsp_busy_read_ticks     = rsp_busy_rd_ff;
   assign rsp_busy_write_ticks    = rsp_busy_wr_ff;
   assign rsp_busy_io_ticks       = rsp_busy_io_ff;
   assign rsp_dev_reads_pending   = rsp_rec_ff.rd.pend;
   assign rsp_dev_writes_pending  = rsp_rec_ff.wr.pend;
   assign rsp_event_error         = rsp_err_ff;

`ifndef SYNTHESIS
   // The global outstanding counts never pass the sum over all devices.
   a_gpend_bound: assert property (@(posedge clock) disable iff (reset)
      (gpend_rd_ff <= GPEND_BITS'(DEVICES * MAX_PENDING)) &&
      (gpend_wr_ff <= GPEND_BITS'(DEVICES * MAX_PENDING)))
      else $error("global outstanding count out of range");

   // A new result appears only out of the write-back step.
   a_rsp_from_wb: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_WB))
      else $error("result raised outside write-back");

   // The update step is always followed by write-back.
   a_calc_to_wb: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CALC) |=> (state_ff == ST_WB))
      else $error("update step not followed by write-back");

   // A start never reports an error.
   a_start_no_err: assert property (@(posedge clock) disable iff (reset)
      (advance && !is_query && (kind == KIND_START)) |=> !rsp_err_ff)
      else $error("start reported an error");
`endif

endmodule
